@@ rtl/tlsrhd_pkg.sv @@
// shared types and constants for the tls record header detector
`default_nettype none

package tlsrhd_pkg;

  // frame layout
  localparam logic [15:0] ETH_HEADER_BYTES  = 16'd14;
  localparam logic [15:0] MIN_CAPTURE_BYTES = 16'd54;
  localparam logic [15:0] LEN_SLACK_BYTES   = 16'd54;
  localparam logic [15:0] TCP_OFFSET_BYTE   = 16'd12;
  localparam logic [15:0] POS_SATURATED     = 16'hFFFF;
  localparam logic [15:0] REC_HDR_LAST      = 16'd4;
  localparam logic [15:0] HS_HDR_LAST       = 16'd8;
  localparam logic [24:0] HS_OVERHEAD       = 25'd9;

  // record and handshake codes
  localparam logic [7:0]  RT_FIRST          = 8'h14;
  localparam logic [7:0]  RT_LAST           = 8'h17;
  localparam logic [7:0]  RT_HANDSHAKE      = 8'h16;
  localparam logic [15:0] VER_FIRST         = 16'h0301;
  localparam logic [15:0] VER_LAST          = 16'h0304;
  localparam logic [7:0]  HS_CLIENT_HELLO   = 8'h01;
  localparam logic [7:0]  HS_SERVER_HELLO   = 8'h02;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [15:0] capture_length;
    logic [7:0]  record_type;
    logic [15:0] record_version;
    logic [15:0] record_length;
    logic [7:0]  handshake_kind;
    logic [23:0] hs_body_len;
    logic        hdr_ok;   // payload start valid and record header fully seen
    logic        hs_seen;  // handshake header fully seen
  } summary_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

@@ rtl/tlsrhd_front.sv @@
// front part: byte position tracking, header field capture, frame summary
`default_nettype none

module tlsrhd_front
  import tlsrhd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic [15:0] capture_length_i,
  input  wire logic        frame_end_i,
  output logic             push_o,
  output summary_t         summary_o
);

  logic [15:0] pos_q, pos_d;
  logic [5:0]  ihb_q, ihb_d;
  logic        ps_known_q, ps_known_d;
  logic [15:0] ps_q, ps_d;
  logic [7:0]  rtype_q, rtype_d;
  logic [15:0] rver_q, rver_d;
  logic [15:0] rlen_q, rlen_d;
  logic [7:0]  hkind_q, hkind_d;
  logic [23:0] hlen_q, hlen_d;

  logic [15:0] offset_pos;
  logic [15:0] offset_pos_end;
  logic [15:0] k;

  always_comb begin
    offset_pos = ETH_HEADER_BYTES + {10'd0, ihb_q} + TCP_OFFSET_BYTE;
    ihb_d      = ihb_q;
    ps_d       = ps_q;
    ps_known_d = ps_known_q;
    if (pos_q == ETH_HEADER_BYTES) begin
      ihb_d = {frame_byte_i[3:0], 2'b00};
    end else if (pos_q == offset_pos) begin
      ps_d       = ETH_HEADER_BYTES + {10'd0, ihb_q} + {10'd0, frame_byte_i[7:4], 2'b00};
      ps_known_d = 1'b1;
    end

    rtype_d = rtype_q;
    rver_d  = rver_q;
    rlen_d  = rlen_q;
    hkind_d = hkind_q;
    hlen_d  = hlen_q;
    k       = pos_q - ps_d;
    if (ps_known_d && pos_q >= ps_d && pos_q != POS_SATURATED) begin
      case (k)
        16'd0:   rtype_d        = frame_byte_i;
        16'd1:   rver_d[15:8]   = frame_byte_i;
        16'd2:   rver_d[7:0]    = frame_byte_i;
        16'd3:   rlen_d[15:8]   = frame_byte_i;
        16'd4:   rlen_d[7:0]    = frame_byte_i;
        16'd5:   hkind_d        = frame_byte_i;
        16'd6:   hlen_d[23:16]  = frame_byte_i;
        16'd7:   hlen_d[15:8]   = frame_byte_i;
        16'd8:   hlen_d[7:0]    = frame_byte_i;
        default: ;
      endcase
    end

    pos_d = (pos_q == POS_SATURATED) ? pos_q : pos_q + 16'd1;

    // the verdict sees the state as left by the last byte
    offset_pos_end = ETH_HEADER_BYTES + {10'd0, ihb_d} + TCP_OFFSET_BYTE;
    summary_o.capture_length   = capture_length_i;
    summary_o.record_type      = rtype_d;
    summary_o.record_version   = rver_d;
    summary_o.record_length    = rlen_d;
    summary_o.handshake_kind   = hkind_d;
    summary_o.hs_body_len      = hlen_d;
    summary_o.hdr_ok  = ps_known_d && (ps_d > offset_pos_end) && (pos_q >= ps_d + REC_HDR_LAST);
    summary_o.hs_seen = pos_q >= ps_d + HS_HDR_LAST;
    push_o            = accept_i && frame_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      ihb_q      <= '0;
      ps_known_q <= 1'b0;
      ps_q       <= '0;
      rtype_q    <= '0;
      rver_q     <= '0;
      rlen_q     <= '0;
      hkind_q    <= '0;
      hlen_q     <= '0;
    end else if (accept_i) begin
      if (frame_end_i) begin
        pos_q      <= '0;
        ihb_q      <= '0;
        ps_known_q <= 1'b0;
        ps_q       <= '0;
        rtype_q    <= '0;
        rver_q     <= '0;
        rlen_q     <= '0;
        hkind_q    <= '0;
        hlen_q     <= '0;
      end else begin
        pos_q      <= pos_d;
        ihb_q      <= ihb_d;
        ps_known_q <= ps_known_d;
        ps_q       <= ps_d;
        rtype_q    <= rtype_d;
        rver_q     <= rver_d;
        rlen_q     <= rlen_d;
        hkind_q    <= hkind_d;
        hlen_q     <= hlen_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/tlsrhd_queue.sv @@
// small queue of frame summaries between front and back
`default_nettype none

module tlsrhd_queue
  import tlsrhd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire summary_t push_data_i,
  input  wire logic    pop_i,
  output summary_t     head_o,
  output queue_status_t status_o
);

  summary_t                 entries_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]     count_q;
  logic                     do_push, do_pop;

  assign status_o.full  = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/tlsrhd_back.sv @@
// back part: judges one frame summary and holds the verdict for the receiver
`default_nettype none

module tlsrhd_back
  import tlsrhd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire summary_t head_i,
  input  wire logic    head_valid_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output logic         is_tls_record_o
);

  logic out_valid_q, out_valid_d;
  logic verdict_q;
  logic verdict;
  logic len_ok, hs_ok;

  always_comb begin
    // a capture shorter than the slack makes the length test pass, as in unsigned wrap
    len_ok = (head_i.capture_length < LEN_SLACK_BYTES) ||
             (head_i.record_length <= head_i.capture_length - LEN_SLACK_BYTES);
    hs_ok  = head_i.hs_seen &&
             (head_i.handshake_kind inside {HS_CLIENT_HELLO, HS_SERVER_HELLO}) &&
             (({1'b0, head_i.hs_body_len} + HS_OVERHEAD) <=
              {9'd0, head_i.record_length});
    verdict = (head_i.capture_length >= MIN_CAPTURE_BYTES) && head_i.hdr_ok &&
              (head_i.record_type inside {[RT_FIRST:RT_LAST]}) &&
              (head_i.record_version inside {[VER_FIRST:VER_LAST]}) && len_ok &&
              ((head_i.record_type != RT_HANDSHAKE) || hs_ok);

    pop_o = head_valid_i && (!out_valid_q || !out_stall_i);
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q <= verdict;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_tls_record_o = verdict_q;

endmodule

`default_nettype wire

@@ rtl/tls_record_header_detector_core.sv @@
// Top level of the tls record header detector.
// Input channel: one captured ethernet frame byte per item (frame_byte_i), with the
// capture length and a last-byte mark (frame_end_i), on in_valid_i / in_stall_o.
// Output channel: one verdict item per frame (is_tls_record_o) on out_valid_o /
// out_stall_i, high when the tcp payload starts with a plausible tls record.
// Throughput: one byte per cycle while in_stall_o is low, frames back to back with no gap.
// The edge that takes the last byte pushes a frame summary into a two-entry queue;
// the back judges the queue head and registers the result as the verdict.
// When the receiver stalls, the verdict holds and later summaries wait in the queue;
// in_stall_o rises only once that queue is full, so input keeps flowing through
// the body of a frame while earlier verdicts wait.
// Reset clears the byte position, the captured header fields, the queue and the
// output valid; capture state also clears after every last byte.
`default_nettype none

module tls_record_header_detector_core
  import tlsrhd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic [15:0] capture_length_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             is_tls_record_o
);

  logic          in_accept;
  logic          q_push;
  logic          q_pop;
  summary_t      front_summary;
  summary_t      q_head;
  queue_status_t q_status;

  assign in_stall_o = q_status.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  tlsrhd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_accept),
    .frame_byte_i     (frame_byte_i),
    .capture_length_i (capture_length_i),
    .frame_end_i      (frame_end_i),
    .push_o           (q_push),
    .summary_o        (front_summary)
  );

  tlsrhd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_summary),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .status_o    (q_status)
  );

  tlsrhd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .head_valid_i    (!q_status.empty),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_tls_record_o (is_tls_record_o)
  );

`ifndef SYNTH
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_status.full))
    else $error("summary pushed into a full queue");

  a_no_invented_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && q_status.empty) |=> !out_valid_o)
    else $error("result shown with nothing queued");

  a_result_from_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!q_status.empty))
    else $error("result appeared without a queued summary");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tls_record_header_detector_core_tb.sv @@
// self-checking testbench for the tls record header detector core
`timescale 1ns / 1ps

module tls_record_header_detector_core_tb;
  import tlsrhd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLDOFF_CYCLES = 400;

  typedef struct {
    bit          noise;  // plain random bytes, no header layout
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  rtype;
    logic [15:0] ver;
    logic [15:0] rlen;
    logic [7:0]  hkind;
    logic [23:0] hlen;
    int unsigned len;
    logic [15:0] caplen;
  } frame_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  frame_byte_i = '0;
  logic [15:0] capture_length_i = '0;
  logic        frame_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        is_tls_record_o;

  // predictor state of the frame being scanned
  logic [15:0] pos_q;
  logic [5:0]  ihl_bytes_q;
  logic [15:0] pstart_q;
  logic [7:0]  rtype_q;
  logic [15:0] rver_q;
  logic [15:0] rlen_q;
  logic [7:0]  hkind_q;
  logic [23:0] hlen_q;

  bit          expected_verdicts[$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holdoff_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned frames_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned verdicts_checked = 0;
  int unsigned verdicts_true = 0;

  tls_record_header_detector_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .frame_byte_i     (frame_byte_i),
    .capture_length_i (capture_length_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .is_tls_record_o  (is_tls_record_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
               expected_verdicts.size());
      $display("tls_record_header_detector_core_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    out_stall_i <= (holdoff_left != 0) || ($urandom_range(99) < stall_pct);
  end

  always @(negedge clk_i) begin
    if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0b with none expected", is_tls_record_o));
      end else begin
        if (is_tls_record_o !== expected_verdicts[0]) begin
          report_mismatch($sformatf("is_tls_record got %0b want %0b", is_tls_record_o,
                                    expected_verdicts[0]));
        end
        verdicts_true += expected_verdicts[0];
        void'(expected_verdicts.pop_front());
        verdicts_checked++;
      end
    end
  end

  function automatic void clear_frame_state();
    pos_q       = '0;
    ihl_bytes_q = '0;
    pstart_q    = POS_SATURATED;
    rtype_q     = '0;
    rver_q      = '0;
    rlen_q      = '0;
    hkind_q     = '0;
    hlen_q      = '0;
  endfunction

  function automatic bit tls_verdict(input int unsigned last_pos, input int unsigned cl);
    int unsigned offs;
    int unsigned ps;
    offs = ETH_HEADER_BYTES + ihl_bytes_q + TCP_OFFSET_BYTE;
    ps   = pstart_q;
    if (cl < MIN_CAPTURE_BYTES) return 1'b0;
    if (pstart_q == POS_SATURATED || ps <= offs) return 1'b0;
    if (last_pos < ps + REC_HDR_LAST) return 1'b0;
    if (rtype_q < RT_FIRST || rtype_q > RT_LAST) return 1'b0;
    if (rver_q < VER_FIRST || rver_q > VER_LAST) return 1'b0;
    if (rlen_q > cl - LEN_SLACK_BYTES) return 1'b0;
    if (rtype_q == RT_HANDSHAKE) begin
      if (last_pos < ps + HS_HDR_LAST) return 1'b0;
      if (hkind_q != HS_CLIENT_HELLO && hkind_q != HS_SERVER_HELLO) return 1'b0;
      if (32'(hlen_q) + HS_OVERHEAD > rlen_q) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the scan by one accepted item
  function automatic void track_byte(input logic [7:0] b, input logic [15:0] cl,
                                     input logic last);
    int unsigned p;
    int unsigned eth;
    int unsigned start;
    p   = pos_q;
    eth = ETH_HEADER_BYTES;
    if (p == eth) begin
      ihl_bytes_q = {b[3:0], 2'b00};
    end else if (p == eth + ihl_bytes_q + TCP_OFFSET_BYTE) begin
      start    = eth + ihl_bytes_q + 4 * b[7:4];
      pstart_q = start[15:0];
    end
    if (pstart_q != POS_SATURATED && p >= pstart_q && p < POS_SATURATED) begin
      case (p - pstart_q)
        0: rtype_q = b;
        1: rver_q[15:8] = b;
        2: rver_q[7:0] = b;
        3: rlen_q[15:8] = b;
        4: rlen_q[7:0] = b;
        5: hkind_q = b;
        6: hlen_q[23:16] = b;
        7: hlen_q[15:8] = b;
        8: hlen_q[7:0] = b;
        default: ;
      endcase
    end
    if (pos_q != POS_SATURATED) pos_q++;
    if (last) begin
      expected_verdicts.push_back(tls_verdict(p, cl));
      clear_frame_state();
    end
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_byte(input logic [7:0] b, input logic [15:0] cl, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    frame_byte_i     <= b;
    capture_length_i <= cl;
    frame_end_i      <= last;
    do @(posedge clk_i); while (in_stall_o);
    track_byte(b, cl, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic int unsigned payload_at(input frame_t f);
    return ETH_HEADER_BYTES + 4 * f.ihl + 4 * f.doff;
  endfunction

  task automatic send_frame(input frame_t f);
    logic [7:0]  frame_q[$];
    logic [71:0] hdr;
    int unsigned ps;
    int unsigned op;
    ps  = payload_at(f);
    op  = ETH_HEADER_BYTES + 4 * f.ihl + TCP_OFFSET_BYTE;
    hdr = {f.rtype, f.ver, f.rlen, f.hkind, f.hlen};
    for (int unsigned i = 0; i < f.len; i++) frame_q.push_back(8'($urandom));
    if (!f.noise) begin
      for (int unsigned j = 0; j < 9; j++) begin
        if (ps + j < f.len) frame_q[ps + j] = hdr[71 - 8 * j -: 8];
      end
      if (f.len > ETH_HEADER_BYTES) frame_q[ETH_HEADER_BYTES] = {4'h4, f.ihl};
      if (op < f.len) frame_q[op] = {f.doff, 4'($urandom)};
    end
    for (int unsigned i = 0; i < f.len; i++) begin
      send_byte(frame_q[i], f.caplen, i == f.len - 1);
    end
    frames_sent++;
  endtask

  // short well-formed client hello whose lengths sit exactly on their limits
  function automatic frame_t hello_frame();
    frame_t f;
    f.noise  = 1'b0;
    f.ihl    = 4'd0;
    f.doff   = 4'd4;
    f.rtype  = RT_HANDSHAKE;
    f.ver    = VER_LAST - 16'd1;
    f.hkind  = HS_CLIENT_HELLO;
    f.len    = payload_at(f) + 9;
    f.caplen = 16'd120;
    f.rlen   = f.caplen - LEN_SLACK_BYTES;
    f.hlen   = 24'(f.rlen) - 24'(HS_OVERHEAD);
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t      f;
    int unsigned slack;
    int unsigned pick;
    f.noise = ($urandom_range(99) < 10);
    f.ihl   = ($urandom_range(99) < 85) ? 4'($urandom_range(7, 0)) : 4'($urandom);
    f.doff  = ($urandom_range(99) < 85) ? 4'($urandom_range(8, 4)) : 4'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) f.rtype = RT_HANDSHAKE;
    else if (pick < 85) f.rtype = 8'($urandom_range(RT_LAST, RT_FIRST));
    else f.rtype = 8'($urandom);
    f.ver = ($urandom_range(99) < 80) ? 16'($urandom_range(VER_LAST, VER_FIRST))
                                      : 16'($urandom);
    if ($urandom_range(99) < 70) begin
      f.hkind = $urandom_range(1) ? HS_CLIENT_HELLO : HS_SERVER_HELLO;
    end else begin
      f.hkind = 8'($urandom);
    end
    f.len = payload_at(f) + 9 + $urandom_range(12);
    if (f.noise) f.len = $urandom_range(80, 1);
    else if ($urandom_range(99) < 10) f.len = $urandom_range(f.len, 1);
    pick = $urandom_range(99);
    if (pick < 75) f.caplen = f.len[15:0];
    else if (pick < 90) f.caplen = 16'($urandom);
    else f.caplen = 16'($urandom_range(60, 40));
    slack = (f.caplen >= MIN_CAPTURE_BYTES) ? f.caplen - LEN_SLACK_BYTES : 0;
    pick = $urandom_range(99);
    if (pick < 40) f.rlen = 16'(slack);
    else if (pick < 70) f.rlen = 16'($urandom_range(slack, 0));
    else if (pick < 85) f.rlen = 16'(slack + 1);
    else f.rlen = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) f.hlen = (f.rlen >= HS_OVERHEAD) ? 24'(f.rlen) - 24'(HS_OVERHEAD) : '0;
    else if (pick < 70) f.hlen = 24'($urandom_range(f.rlen, 0));
    else if (pick < 85) f.hlen = 24'(f.rlen) - 24'(HS_OVERHEAD) + 24'd1;
    else f.hlen = 24'($urandom);
    return f;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_capture_length();
    frame_t f;
    f = hello_frame();
    f.rtype = RT_LAST;
    f.rlen  = '0;
    f.len   = 1;
    f.caplen = '0;
    send_frame(f);
    f.caplen = 16'hFFFF;
    send_frame(f);
    f.len = payload_at(f) + 9;
    f.caplen = MIN_CAPTURE_BYTES - 16'd1;
    send_frame(f);
    f.caplen = MIN_CAPTURE_BYTES;
    send_frame(f);
  endtask

  task automatic test_record_fields();
    frame_t f;
    f = hello_frame();
    send_frame(f);
    f.rlen = f.rlen + 16'd1;
    f.hlen = 24'(f.rlen) - 24'(HS_OVERHEAD);
    send_frame(f);
    f = hello_frame();
    f.hkind = '0;
    f.rtype = RT_FIRST - 8'd1;
    send_frame(f);
    f.rtype = RT_FIRST;
    send_frame(f);
    f.rtype = RT_LAST;
    send_frame(f);
    f.rtype = RT_LAST + 8'd1;
    send_frame(f);
    f.rtype = RT_FIRST;
    f.ver = VER_FIRST - 16'd1;
    send_frame(f);
    f.ver = VER_FIRST;
    send_frame(f);
    f.ver = VER_LAST;
    send_frame(f);
    f.ver = VER_LAST + 16'd1;
    send_frame(f);
  endtask

  task automatic test_handshake_fields();
    frame_t f;
    f = hello_frame();
    f.hkind = HS_CLIENT_HELLO - 8'd1;
    send_frame(f);
    f.hkind = HS_SERVER_HELLO;
    send_frame(f);
    f.hkind = HS_SERVER_HELLO + 8'd1;
    send_frame(f);
    f.hkind = HS_CLIENT_HELLO;
    f.hlen = f.hlen + 24'd1;
    send_frame(f);
  endtask

  // frames that stop inside or just at the end of the record or handshake header
  task automatic test_short_frames();
    frame_t f;
    f = hello_frame();
    f.caplen = 16'd200;
    f.rlen = 16'd100;
    f.hlen = 24'd50;
    f.len = payload_at(f) + HS_HDR_LAST;
    send_frame(f);
    f.len = payload_at(f) + HS_HDR_LAST + 1;
    send_frame(f);
    f.rtype = RT_FIRST;
    f.len = payload_at(f) + REC_HDR_LAST;
    send_frame(f);
    f.len = payload_at(f) + REC_HDR_LAST + 1;
    send_frame(f);
  endtask

  // payload before, at or just past the data offset byte, smallest and largest headers
  task automatic test_data_offsets();
    frame_t f;
    f = hello_frame();
    for (int unsigned d = 0; d <= 4; d++) begin
      f.doff = 4'(d);
      f.len = payload_at(f) + 9;
      send_frame(f);
    end
    f.ihl = 4'd5;
    f.doff = 4'd5;
    f.len = payload_at(f) + 9;
    send_frame(f);
    f.ihl = 4'd15;
    f.doff = 4'd15;
    f.len = payload_at(f) + 9;
    f.caplen = f.len[15:0];
    f.rlen = f.caplen - LEN_SLACK_BYTES;
    f.hlen = 24'(f.rlen) - 24'(HS_OVERHEAD);
    send_frame(f);
  endtask

  task automatic test_random_traffic(input int unsigned sender_idle,
                                     input int unsigned receiver_stall,
                                     input int unsigned min_bytes,
                                     input int unsigned min_frames);
    int unsigned bytes_start;
    int unsigned frames_start;
    idle_pct     = sender_idle;
    stall_pct    = receiver_stall;
    bytes_start  = bytes_sent;
    frames_start = frames_sent;
    while (bytes_sent - bytes_start < min_bytes || frames_sent - frames_start < min_frames) begin
      send_frame(random_frame());
    end
    wait_drained();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // receiver holds off while short frames keep coming, so the input stalls
  task automatic test_backpressure();
    frame_t f;
    @(posedge clk_i);
    holdoff_left <= HOLDOFF_CYCLES;
    @(negedge clk_i);
    for (int unsigned n = 0; n < 15; n++) begin
      f = random_frame();
      f.len = $urandom_range(6, 1);
      if (n % 5 == 0) f = hello_frame();
      send_frame(f);
    end
    wait_drained();
  endtask

  initial begin
    clear_frame_state();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_capture_length();
    test_record_fields();
    test_handshake_fields();
    test_short_frames();
    test_data_offsets();
    wait_drained();
    test_random_traffic(0, 0, 100, 2);
    test_random_traffic(66, 0, 100, 2);
    test_random_traffic(0, 66, 100, 2);
    test_random_traffic(22, 22, 100, 2);
    test_backpressure();

    if (expected_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
    end
    $display("sent %0d frames in %0d bytes; checked %0d verdicts, %0d of them true",
             frames_sent, bytes_sent, verdicts_checked, verdicts_true);
    $display("covered field limits, short frames, data offsets, idle/stall mixes, hold-off");
    if (error_count == 0) begin
      $display("tls_record_header_detector_core_tb: done, clean");
    end else begin
      $display("tls_record_header_detector_core_tb: done, errors");
    end
    $finish;
  end

endmodule
